// File: rtl/core/arpc_pkg.sv
// Package for the address resolution cache: opcodes, result kinds, shared types.
// No dependencies.
package arpc_pkg;

   localparam int unsigned EntryDepthDefault = 32;
   localparam int unsigned ReqDepthDefault   = 16;
   localparam logic [15:0] TimeoutReset      = 16'd15;
   localparam logic [2:0]  MaxSendsReset     = 3'd5;
   localparam int unsigned CmdQueueDepth     = 2;

   typedef enum logic [2:0] {
      OP_LOOKUP = 3'd0,
      OP_INSERT = 3'd1,
      OP_QUEUE  = 3'd2,
      OP_TICK   = 3'd3,
      OP_REMOVE = 3'd4,
      OP_CLEAR  = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      KIND_LOOKUP  = 3'd0,
      KIND_INSERT  = 3'd1,
      KIND_QUEUED  = 3'd2,
      KIND_SEND    = 3'd3,
      KIND_GAVE_UP = 3'd4,
      KIND_TICK    = 3'd5,
      KIND_DONE    = 3'd6
   } kind_type;

   typedef enum logic {
      CSR_TIMEOUT   = 1'b0,
      CSR_MAX_SENDS = 1'b1
   } csr_idx_type;

   // classified command passed from front to back
   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] ip;
      logic [47:0] mac;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic        hit;
      logic [47:0] mac_res;
      logic [31:0] ip_res;
      logic        full_res;
      logic        last;
   } rsp_type;

endpackage

// File: rtl/core/arpc_if.sv
// Valid/ready channel interfaces for the address resolution cache.
// No dependencies.
interface arpc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [31:0] ip;
   logic [47:0] mac;
   modport source (output valid, op, ip, mac, input ready);
   modport sink   (input valid, op, ip, mac, output ready);
endinterface

interface arpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic        hit;
   logic [47:0] mac_res;
   logic [31:0] ip_res;
   logic        full_res;
   logic        last;
   modport source (output valid, kind, hit, mac_res, ip_res, full_res, last, input ready);
   modport sink   (input valid, kind, hit, mac_res, ip_res, full_res, last, output ready);
endinterface

interface arpc_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/arpc_front.sv
// Front end: accepts request items and queues them as commands for the back end.
// Depends on arpc_pkg.
module arpc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  arpc_pkg::cmd_type in_cmd,
   output logic              cmd_valid,
   input  logic              cmd_take,
   output arpc_pkg::cmd_type cmd_out
);
   import arpc_pkg::*;

   localparam int unsigned PtrW = $clog2(CmdQueueDepth);

   cmd_type            q_mem [CmdQueueDepth];
   logic [PtrW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]      cnt_ff, cnt_in;
   logic               push, pop;

   assign in_ready  = (cnt_ff != (PtrW+1)'(CmdQueueDepth));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_out   = q_mem[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = cmd_valid && cmd_take;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_mem[wr_ff] <= in_cmd;
   end
endmodule

// File: rtl/core/arpc_back.sv
// Back end: entry and request tables, walked slot by slot by a sequencer.
// Depends on arpc_pkg.
module arpc_back #(
   parameter int unsigned ENTRY_DEPTH = arpc_pkg::EntryDepthDefault,
   parameter int unsigned REQ_DEPTH   = arpc_pkg::ReqDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  arpc_pkg::cmd_type cmd_in,
   input  logic [15:0]       timeout_ticks,
   input  logic [2:0]        max_sends,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output arpc_pkg::rsp_type rsp_out
);
   import arpc_pkg::*;

   localparam int unsigned EW = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
   localparam int unsigned RW = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ESCAN, ST_EREAD, ST_RSCAN, ST_RREAD, ST_EMIT
   } state_type;

   // entry store: memories, valid bits in flops
   logic [31:0] e_addr_mem [ENTRY_DEPTH];
   logic [47:0] e_hw_mem   [ENTRY_DEPTH];
   logic [15:0] e_age_mem  [ENTRY_DEPTH];
   logic [ENTRY_DEPTH-1:0] e_valid_ff;
   logic [31:0] r_addr_mem [REQ_DEPTH];
   logic [2:0]  r_sent_mem [REQ_DEPTH];
   logic [REQ_DEPTH-1:0] r_used_ff;

   state_type   state_ff;
   cmd_type     cmd_ff;
   logic [EW:0] ei_ff;
   logic [RW:0] ri_ff;
   logic [31:0] ea_rd_ff, ra_rd_ff;
   logic [47:0] eh_rd_ff;
   logic [15:0] eg_rd_ff;
   logic [2:0]  rs_rd_ff;
   logic        hit_ff, free_ok_ff, rfree_ok_ff;
   logic [EW-1:0] efree_ff;
   logic [RW-1:0] rfree_ff, rmatch_ff;
   logic        rmatch_ok_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic [EW-1:0] ei;
   logic [RW-1:0] ri;
   assign ei = ei_ff[EW-1:0];
   assign ri = ri_ff[RW-1:0];

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out   = rsp_ff;
   assign cmd_take  = (state_ff == ST_IDLE) && cmd_valid && !rsp_valid_ff;

   function automatic rsp_type mk(input logic [2:0] k, input logic h, input logic [47:0] m,
                                  input logic [31:0] a, input logic f, input logic l);
      rsp_type r;
      r.kind = k; r.hit = h; r.mac_res = m; r.ip_res = a; r.full_res = f; r.last = l;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      // registered memory reads for the current scan index
      ea_rd_ff <= e_addr_mem[ei];
      eh_rd_ff <= e_hw_mem[ei];
      eg_rd_ff <= e_age_mem[ei];
      ra_rd_ff <= r_addr_mem[ri];
      rs_rd_ff <= r_sent_mem[ri];
      if (reset) begin
         state_ff     <= ST_IDLE;
         e_valid_ff   <= '0;
         r_used_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (cmd_take) begin
                  cmd_ff       <= cmd_in;
                  ei_ff        <= '0;
                  ri_ff        <= '0;
                  hit_ff       <= 1'b0;
                  free_ok_ff   <= 1'b0;
                  rfree_ok_ff  <= 1'b0;
                  rmatch_ok_ff <= 1'b0;
                  case (cmd_in.op)
                     OP_LOOKUP, OP_INSERT, OP_TICK: state_ff <= ST_ESCAN;
                     OP_QUEUE, OP_REMOVE:           state_ff <= ST_RSCAN;
                     OP_CLEAR: begin
                        e_valid_ff   <= '0;
                        r_used_ff    <= '0;
                        rsp_ff       <= mk(KIND_DONE, 1'b0, '0, '0, 1'b0, 1'b1);
                        rsp_valid_ff <= 1'b1;
                     end
                     default: begin
                        rsp_ff       <= mk(KIND_DONE, 1'b0, '0, '0, 1'b0, 1'b1);
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            ST_ESCAN: begin
               // read issued at ei; check after the register
               if (ei_ff == (EW+1)'(ENTRY_DEPTH)) begin
                  if (cmd_ff.op == OP_LOOKUP) begin
                     state_ff <= ST_EMIT;
                  end else if (cmd_ff.op == OP_INSERT) begin
                     if (free_ok_ff) begin
                        e_addr_mem[efree_ff] <= cmd_ff.ip;
                        e_hw_mem[efree_ff]   <= cmd_ff.mac;
                        e_age_mem[efree_ff]  <= '0;
                        e_valid_ff[efree_ff] <= 1'b1;
                     end
                     ri_ff    <= '0;
                     state_ff <= ST_RSCAN;
                  end else begin
                     ri_ff    <= '0;
                     state_ff <= ST_RSCAN;
                  end
               end else if (!e_valid_ff[ei]) begin
                  if (!free_ok_ff) begin
                     free_ok_ff <= 1'b1;
                     efree_ff   <= ei;
                  end
                  ei_ff <= ei_ff + 1'b1;
               end else begin
                  state_ff <= ST_EREAD;
               end
            end
            ST_EREAD: begin
               state_ff <= ST_ESCAN;
               if (cmd_ff.op == OP_LOOKUP && ea_rd_ff == cmd_ff.ip) begin
                  hit_ff         <= 1'b1;
                  rsp_ff.mac_res <= eh_rd_ff;
                  // first match wins: jump to the end of the scan
                  ei_ff          <= (EW+1)'(ENTRY_DEPTH);
               end else begin
                  ei_ff <= ei_ff + 1'b1;
               end
               if (cmd_ff.op == OP_TICK) begin
                  if (eg_rd_ff >= timeout_ticks) e_valid_ff[ei] <= 1'b0;
                  else e_age_mem[ei] <= eg_rd_ff + 16'd1;
               end
            end
            ST_RSCAN: begin
               if (ri_ff == (RW+1)'(REQ_DEPTH)) begin
                  if (cmd_ff.op == OP_QUEUE && !rmatch_ok_ff && rfree_ok_ff) begin
                     r_addr_mem[rfree_ff] <= cmd_ff.ip;
                     r_sent_mem[rfree_ff] <= '0;
                     r_used_ff[rfree_ff]  <= 1'b1;
                  end
                  if (cmd_ff.op == OP_REMOVE && rmatch_ok_ff)
                     r_used_ff[rmatch_ff] <= 1'b0;
                  state_ff <= ST_EMIT;
               end else if (!r_used_ff[ri]) begin
                  if (!rfree_ok_ff) begin
                     rfree_ok_ff <= 1'b1;
                     rfree_ff    <= ri;
                  end
                  ri_ff <= ri_ff + 1'b1;
               end else if (!(cmd_ff.op == OP_TICK && rsp_valid_ff)) begin
                  state_ff <= ST_RREAD;
               end
            end
            ST_RREAD: begin
               state_ff <= ST_RSCAN;
               ri_ff    <= ri_ff + 1'b1;
               if (cmd_ff.op == OP_TICK) begin
                  rsp_valid_ff <= 1'b1;
                  if (rs_rd_ff >= max_sends) begin
                     rsp_ff <= mk(KIND_GAVE_UP, 1'b0, '0, ra_rd_ff, 1'b0, 1'b0);
                     r_used_ff[ri] <= 1'b0;
                  end else begin
                     rsp_ff <= mk(KIND_SEND, 1'b0, '0, ra_rd_ff, 1'b0, 1'b0);
                     r_sent_mem[ri] <= rs_rd_ff + 3'd1;
                  end
               end else if (ra_rd_ff == cmd_ff.ip && !rmatch_ok_ff) begin
                  rmatch_ok_ff <= 1'b1;
                  rmatch_ff    <= ri;
               end
            end
            ST_EMIT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
                  case (cmd_ff.op)
                     OP_LOOKUP: rsp_ff <= mk(KIND_LOOKUP, hit_ff,
                                             hit_ff ? rsp_ff.mac_res : 48'd0, '0, 1'b0, 1'b1);
                     OP_INSERT: rsp_ff <= mk(KIND_INSERT, rmatch_ok_ff, '0, '0,
                                             !free_ok_ff, 1'b1);
                     OP_QUEUE:  rsp_ff <= mk(KIND_QUEUED, 1'b0, '0, '0,
                                             !rmatch_ok_ff && !rfree_ok_ff, 1'b1);
                     OP_TICK:   rsp_ff <= mk(KIND_TICK, 1'b0, '0, '0, 1'b0, 1'b1);
                     default:   rsp_ff <= mk(KIND_DONE, 1'b0, '0, '0, 1'b0, 1'b1);
                  endcase
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// File: rtl/core/arp_cache_with_request_retry_top.sv
// Top level of the address resolution cache with request retry.
// Depends on arpc_pkg, arpc_if, arpc_front, arpc_back.
//
// Channels: req_ carries op/ip/mac items, rsp_ returns result items, csr_ writes
// timeout_ticks (index 0) and max_sends (index 1). All are valid/ready.
// Items go into a two-deep command queue and are executed one at a time by the
// back end, which walks the tables slot by slot.
// Lookup walks the entry table; insert walks it and then the request table;
// queue/remove walk the request table; a tick walks both tables and
// emits one send/gave-up item per pending request, then tick-done. Clear and
// unknown ops answer straight from idle. Throughput is set by the table walk.
// The last result of every item carries last=1.
// Reset clears valid bits, queue and configuration (timeout 15, max sends 5).
// When rsp_ready is low the back end holds its result and stalls; the front
// queue still takes up to two more items.
module arp_cache_with_request_retry_top #(
   parameter int unsigned ENTRY_DEPTH = arpc_pkg::EntryDepthDefault,
   parameter int unsigned REQ_DEPTH   = arpc_pkg::ReqDepthDefault
) (
   input logic clock,
   input logic reset,
   arpc_req_if.sink   req,
   arpc_rsp_if.source rsp,
   arpc_csr_if.sink   csr
);
   import arpc_pkg::*;

   logic [15:0] timeout_ff;
   logic [2:0]  max_sends_ff;
   cmd_type     in_cmd, cmd_q;
   logic        cmd_valid, cmd_take;
   rsp_type     rsp_d;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TimeoutReset;
         max_sends_ff <= MaxSendsReset;
      end else if (csr.valid) begin
         if (csr.index == CSR_TIMEOUT) timeout_ff <= csr.data;
         else max_sends_ff <= csr.data[2:0];
      end
   end

   assign in_cmd.op  = req.op;
   assign in_cmd.ip  = req.ip;
   assign in_cmd.mac = req.mac;

   arpc_front u_front (
      .clock, .reset,
      .in_valid (req.valid), .in_ready (req.ready), .in_cmd (in_cmd),
      .cmd_valid, .cmd_take, .cmd_out (cmd_q)
   );

   arpc_back #(.ENTRY_DEPTH(ENTRY_DEPTH), .REQ_DEPTH(REQ_DEPTH)) u_back (
      .clock, .reset,
      .cmd_valid, .cmd_take, .cmd_in (cmd_q),
      .timeout_ticks (timeout_ff), .max_sends (max_sends_ff),
      .rsp_valid (rsp.valid), .rsp_ready (rsp.ready), .rsp_out (rsp_d)
   );

   assign rsp.kind     = rsp_d.kind;
   assign rsp.hit      = rsp_d.hit;
   assign rsp.mac_res  = rsp_d.mac_res;
   assign rsp.ip_res   = rsp_d.ip_res;
   assign rsp.full_res = rsp_d.full_res;
   assign rsp.last     = rsp_d.last;
endmodule

// File: rtl/core/arpc_checker.sv
// Port-level checks for the address resolution cache, bound to the top level.
// Depends on arpc_pkg and the top level's ports.
module arpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic        rsp_hit,
   input logic [47:0] rsp_mac_res,
   input logic [31:0] rsp_ip_res,
   input logic        rsp_last
);
   import arpc_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
      else $error("result dropped under stall");
   a_mac: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_mac_res == '0)
      else $error("mac without hit");
   a_ip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_SEND && rsp_kind != KIND_GAVE_UP |-> rsp_ip_res == '0)
      else $error("stray ip_res");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_SEND || rsp_kind == KIND_GAVE_UP) |-> !rsp_last)
      else $error("send marked last");
endmodule

bind arp_cache_with_request_retry_top arpc_checker u_chk (
   .clock, .reset,
   .rsp_valid (rsp.valid), .rsp_ready (rsp.ready), .rsp_kind (rsp.kind),
   .rsp_hit (rsp.hit), .rsp_mac_res (rsp.mac_res), .rsp_ip_res (rsp.ip_res),
   .rsp_last (rsp.last)
);
